// ----- design/pifm_pkg.sv -----
// Shared types and constants of the peak interval frequency meter.
package pifm_pkg;

    localparam int FRAME_LEN = 100;

    localparam int SAMPLE_W = 10;
    localparam int TIME_W   = 16;
    localparam int IDX_W    = 10;
    localparam int SUM_W    = 16;
    localparam int CNT_W    = 10;
    localparam int SCALE_W  = 16;
    localparam int WHOLE_W  = 8;
    localparam int HUND_W   = 7;

    localparam int DVD_W    = 23;
    localparam int DVS_W    = 16;
    localparam int STEP_W   = $clog2(DVD_W + 1);

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(8000);
    localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};
    localparam int                 HUND_BASE   = 100;
    localparam int                 WHOLE_MAX   = 255;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [TIME_W-1:0]   time_t;
    typedef logic [SUM_W-1:0]    sum_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [SCALE_W-1:0]  scale_t;
    typedef logic [DVD_W-1:0]    dividend_t;
    typedef logic [DVS_W-1:0]    divisor_t;

    typedef struct packed {
        logic last;
        sum_t sum;
        cnt_t count;
    } frame_t;

    typedef struct packed {
        logic      start;
        dividend_t dividend;
        divisor_t  divisor;
    } div_req_t;

    typedef struct packed {
        logic      done;
        dividend_t quotient;
        divisor_t  remainder;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_FREQ,
        ST_HUND,
        ST_EMIT
    } state_t;

endpackage

// ----- design/pifm_if.sv -----
// Valid/ready channel interfaces for sample items and result items.
interface pifm_sample_if;
    import pifm_pkg::*;
    logic    valid;
    logic    ready;
    sample_t sample;
    time_t   timestamp;
    logic    frame_end;

    modport source (output valid, output sample, output timestamp, output frame_end,
                    input ready);
    modport sink (input valid, input sample, input timestamp, input frame_end,
                  output ready);
endinterface

interface pifm_result_if;
    import pifm_pkg::*;
    logic               valid;
    logic               ready;
    logic [WHOLE_W-1:0] freq_whole;
    logic [HUND_W-1:0]  freq_hundredths;
    logic [15:0]        avg_period;
    logic               no_period;
    logic               over_range;

    modport source (output valid, output freq_whole, output freq_hundredths,
                    output avg_period, output no_period, output over_range,
                    input ready);
    modport sink (input valid, input freq_whole, input freq_hundredths,
                  input avg_period, input no_period, input over_range,
                  output ready);
endinterface

// ----- design/peak_interval_frequency_meter_top.sv -----
// Top level: sequencer over the shared divider, scale register and result register.
// A sample that does not end a frame is taken while ready stays high.
// A frame-ending sample runs up to three divisions (mean, whole part,
// hundredths from its remainder): ready is low until the result item is loaded
// into the result register, which waits until the previous item has been taken.
// A frame with no interval skips the divisions. Reset clears frame state, scale_reg = 8000.
module peak_interval_frequency_meter_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  pifm_pkg::scale_t     cfg_wdata,
    pifm_sample_if.sink          samples,
    pifm_result_if.source        results
);
    import pifm_pkg::*;

    state_t state_reg, state_next;
    scale_t scale_reg;

    frame_t   frame;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     accept;

    logic [15:0]        avg_reg, avg_next;
    logic [WHOLE_W-1:0] whole_reg, whole_next;
    logic [HUND_W-1:0]  hund_reg, hund_next;
    logic               nop_reg, nop_next;
    logic               over_reg, over_next;

    logic               out_valid_reg, out_valid_next;
    logic [WHOLE_W-1:0] out_whole_reg;
    logic [HUND_W-1:0]  out_hund_reg;
    logic [15:0]        out_avg_reg;
    logic               out_nop_reg;
    logic               out_over_reg;
    logic               load_out;

    pifm_peak u_peak (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sample    (samples.sample),
        .timestamp (samples.timestamp),
        .frame_end (samples.frame_end),
        .frame     (frame)
    );

    pifm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        state_next = state_reg;
        avg_next   = avg_reg;
        whole_next = whole_reg;
        hund_next  = hund_reg;
        nop_next   = nop_reg;
        over_next  = over_reg;
        div_req    = '0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && frame.last)
                begin
                    avg_next   = '0;
                    whole_next = '0;
                    hund_next  = '0;
                    over_next  = 1'b0;
                    nop_next   = 1'b1;
                    if (frame.count == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DVD_W'(frame.sum);
                        div_req.divisor  = DVS_W'(frame.count);
                        state_next       = ST_AVG;
                    end
                end
            end
            ST_AVG:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient[15:0] == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        avg_next         = div_rsp.quotient[15:0];
                        div_req.start    = 1'b1;
                        div_req.dividend = DVD_W'(scale_reg);
                        div_req.divisor  = DVS_W'(div_rsp.quotient[15:0]);
                        state_next       = ST_FREQ;
                    end
                end
            end
            ST_FREQ:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient > DVD_W'(WHOLE_MAX))
                    begin
                        over_next  = 1'b1;
                        whole_next = WHOLE_W'(WHOLE_MAX);
                    end
                    else
                    begin
                        over_next  = 1'b0;
                        whole_next = div_rsp.quotient[WHOLE_W-1:0];
                    end
                    // hundredths from the remainder of the whole part
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(div_rsp.remainder) * DVD_W'(HUND_BASE);
                    div_req.divisor  = DVS_W'(avg_reg);
                    state_next       = ST_HUND;
                end
            end
            ST_HUND:
            begin
                if (div_rsp.done)
                begin
                    nop_next   = 1'b0;
                    hund_next  = div_rsp.quotient[HUND_W-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !results.ready;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scale_reg     <= SCALE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                scale_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg   <= avg_next;
        whole_reg <= whole_next;
        hund_reg  <= hund_next;
        nop_reg   <= nop_next;
        over_reg  <= over_next;
        if (load_out)
        begin
            out_whole_reg <= whole_reg;
            out_hund_reg  <= hund_reg;
            out_avg_reg   <= avg_reg;
            out_nop_reg   <= nop_reg;
            out_over_reg  <= over_reg;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.freq_whole      = out_whole_reg;
    assign results.freq_hundredths = out_hund_reg;
    assign results.avg_period      = out_avg_reg;
    assign results.no_period       = out_nop_reg;
    assign results.over_range      = out_over_reg;

endmodule

// ----- design/pifm_peak.sv -----
// Peak detection and per-frame interval accumulation.
module pifm_peak (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  pifm_pkg::sample_t sample,
    input  pifm_pkg::time_t   timestamp,
    input  logic              frame_end,
    output pifm_pkg::frame_t  frame
);
    import pifm_pkg::*;

    sample_t          older_reg;
    sample_t          middle_reg;
    time_t            mid_time_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             seen_reg;
    time_t            peak_time_reg;
    sum_t             sum_reg;
    cnt_t             count_reg;

    logic is_peak;
    logic last;
    time_t delta;
    sum_t sum_next;
    cnt_t count_next;

    always_comb
    begin
        is_peak = (idx_reg >= IDX_W'(2)) && (middle_reg >= older_reg) && (middle_reg > sample);
        last    = frame_end || (({1'b0, idx_reg} + (IDX_W+1)'(1)) >= (IDX_W+1)'(FRAME_LEN));
        delta   = mid_time_reg - peak_time_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        if (is_peak && seen_reg)
        begin
            sum_next = sum_reg + delta;
            if (count_reg != CNT_MAX)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        frame.last  = last;
        frame.sum   = sum_next;
        frame.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg     <= '0;
            middle_reg    <= '0;
            mid_time_reg  <= '0;
            idx_reg       <= '0;
            seen_reg      <= 1'b0;
            peak_time_reg <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
        end
        else if (accept)
        begin
            older_reg    <= middle_reg;
            middle_reg   <= sample;
            mid_time_reg <= timestamp;
            if (last)
            begin
                // clear frame totals
                idx_reg       <= '0;
                seen_reg      <= 1'b0;
                peak_time_reg <= '0;
                sum_reg       <= '0;
                count_reg     <= '0;
            end
            else
            begin
                idx_reg   <= idx_reg + IDX_W'(1);
                sum_reg   <= sum_next;
                count_reg <= count_next;
                if (is_peak)
                begin
                    seen_reg      <= 1'b1;
                    peak_time_reg <= mid_time_reg;
                end
            end
        end
    end

endmodule

// ----- design/pifm_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module pifm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  pifm_pkg::div_req_t req,
    output pifm_pkg::div_rsp_t rsp
);
    import pifm_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    dividend_t         dvd_reg;
    divisor_t          dvs_reg;
    divisor_t          rem_reg;

    logic [DVS_W+1:0] diff;
    logic             qbit;
    divisor_t         rem_next;

    always_comb
    begin
        diff     = {1'b0, rem_reg, dvd_reg[DVD_W-1]} - {2'b00, dvs_reg};
        qbit     = !diff[DVS_W+1];
        rem_next = qbit ? diff[DVS_W-1:0] : {rem_reg[DVS_W-2:0], dvd_reg[DVD_W-1]};
        rsp.done      = done_reg;
        rsp.quotient  = dvd_reg;
        rsp.remainder = rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

endmodule
